### design/m3inv_pkg.sv
// Shared constants and types for the 3x3 adjugate inverse block.
// No dependencies; every other file in this folder imports it.
package m3inv_pkg;

  localparam int unsigned NUM_ENT = 9;
  localparam int unsigned DET_W   = 64;

  typedef logic [DET_W-1:0] det_word_t;

  localparam det_word_t DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
  localparam det_word_t DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

  // adjugate entry k = m[p]*m[q] - m[r]*m[s], columns p q r s
  localparam int unsigned ADJ_IDX [NUM_ENT][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

endpackage

### design/m3inv_adj.sv
// Adjugate front end: two stages, pair products then 2x2 minors.
// Depends on m3inv_pkg.
module m3inv_adj #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i   [m3inv_pkg::NUM_ENT],
  output logic signed [2*W:0] adj_o [m3inv_pkg::NUM_ENT],
  output logic signed [W-1:0] row_o [3]
);
  import m3inv_pkg::*;

  logic signed [2*W-1:0] pa_q [NUM_ENT];
  logic signed [2*W-1:0] pb_q [NUM_ENT];
  logic signed [W-1:0]   row1_q [3];
  logic signed [W-1:0]   row2_q [3];
  logic signed [2*W:0]   adj_q [NUM_ENT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        pa_q[k] <= a_i[ADJ_IDX[k][0]] * a_i[ADJ_IDX[k][1]];
        pb_q[k] <= a_i[ADJ_IDX[k][2]] * a_i[ADJ_IDX[k][3]];
      end
      for (int c = 0; c < 3; c++) begin
        row1_q[c] <= a_i[c];
        row2_q[c] <= row1_q[c];
      end
      for (int k = 0; k < NUM_ENT; k++) begin
        adj_q[k] <= $signed({pa_q[k][2*W-1], pa_q[k]}) - $signed({pb_q[k][2*W-1], pb_q[k]});
      end
    end
  end

  assign adj_o = adj_q;
  assign row_o = row2_q;

endmodule

### design/m3inv_det.sv
// Determinant along the first row: split partial products, then sum.
// The adjugate rides along two stages to stay aligned. Depends on m3inv_pkg.
module m3inv_det #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [2*W:0]   adj_i [m3inv_pkg::NUM_ENT],
  input  logic signed [W-1:0]   row_i [3],
  output logic signed [2*W:0]   adj_o [m3inv_pkg::NUM_ENT],
  output logic signed [3*W+1:0] det_o
);
  import m3inv_pkg::*;

  localparam int unsigned DW = 3*W + 2;

  logic signed [2*W:0] sel [3];
  logic signed [2*W:0] pl_q [3];
  logic signed [2*W:0] ph_q [3];
  logic signed [2*W:0] adj1_q [NUM_ENT];
  logic signed [2*W:0] adj2_q [NUM_ENT];
  logic [DW-1:0]       sum_d;
  logic signed [DW-1:0] det_q;

  assign sel[0] = adj_i[0];
  assign sel[1] = adj_i[3];
  assign sel[2] = adj_i[6];

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      sum_d = sum_d + {{(DW-3*W-1){ph_q[i][2*W]}}, ph_q[i], {W{1'b0}}}
                    + {{(DW-2*W-1){pl_q[i][2*W]}}, pl_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= row_i[i] * $signed({1'b0, sel[i][W-1:0]});
        ph_q[i] <= row_i[i] * $signed(sel[i][2*W:W]);
      end
      adj1_q <= adj_i;
      adj2_q <= adj1_q;
      det_q  <= $signed(sum_d);
    end
  end

  assign adj_o = adj2_q;
  assign det_o = det_q;

endmodule

### design/m3inv_div.sv
// One inverse entry: (|adj| << 2F) / |det|, one quotient bit per stage,
// with a range check up front and saturation at the end. Depends on m3inv_pkg.
module m3inv_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [2*W:0] adj_i,
  input  logic [3*W:0]        dmag_i,
  input  logic                dneg_i,
  output logic signed [W-1:0] q_o
);
  import m3inv_pkg::*;

  localparam int unsigned NW = 2*W + 1 + 2*F;
  localparam int unsigned CW = (NW > 4*W) ? NW : 4*W;

  logic [2*W:0]   amag;
  logic [CW-1:0]  num;
  logic [CW-1:0]  den;

  logic [CW-1:0]  rem_q [W];
  logic [CW-1:0]  den_q [W];
  logic [W-2:0]   quo_q [W];
  logic           ovf_q [W];
  logic           neg_q [W];

  assign amag = adj_i[2*W] ? (2*W+1)'(-adj_i) : adj_i;
  assign num  = CW'(amag) << (2*F);
  assign den  = CW'(dmag_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num;
      den_q[0] <= den;
      quo_q[0] <= '0;
      // quotient of 2^(W-1) or more saturates either way
      ovf_q[0] <= num >= (den << (W-1));
      neg_q[0] <= adj_i[2*W] ^ dneg_i;
    end
  end

  for (genvar j = 1; j < W; j++) begin : g_bit
    localparam int unsigned K = W - 1 - j;
    logic [CW-1:0] sh;
    logic          ge;
    logic [W-2:0]  quo_d;
    assign sh    = den_q[j-1] << K;
    assign ge    = rem_q[j-1] >= sh;
    assign quo_d = quo_q[j-1] | ((W-1)'(ge) << K);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_q[j-1] - sh : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_d;
        ovf_q[j] <= ovf_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
  end

  always_comb begin
    if (ovf_q[W-1]) begin
      q_o = neg_q[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (neg_q[W-1]) begin
      q_o = -$signed({1'b0, quo_q[W-1]});
    end else begin
      q_o = $signed({1'b0, quo_q[W-1]});
    end
  end

endmodule

### design/matrix3x3_inverse_adjugate_top.sv
// Top level of the 3x3 adjugate inverse: adjugate, determinant, nine dividers.
// Depends on m3inv_pkg, m3inv_adj, m3inv_det and m3inv_div.
//
//  channel | valid       | stall        | word
//  --------+-------------+--------------+-----------------------------------------
//  in      | in_valid_i  | in_stall_o   | a_r0c0_i .. a_r2c2_i
//  out     | out_valid_o | out_stall_i  | inv_r0c0_o .. inv_r2c2_o, det_value_o,
//          |             |              | singular_o
//
// One matrix per cycle while the output is not stalled; the dividers
// resolve one quotient bit per stage.
// Reset clears only the valid bits of the pipeline.
// A held output word freezes the whole pipeline and stalls the input.
module matrix3x3_inverse_adjugate_top #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [ELEM_WIDTH-1:0]  a_r0c0_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r0c1_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r0c2_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r1c0_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r1c1_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r1c2_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r2c0_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r2c1_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_r2c2_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ELEM_WIDTH-1:0]  inv_r0c0_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r0c1_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r0c2_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r1c0_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r1c1_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r1c2_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r2c0_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r2c1_o,
  output logic signed [ELEM_WIDTH-1:0]  inv_r2c2_o,
  output m3inv_pkg::det_word_t          det_value_o,
  output logic                          singular_o
);
  import m3inv_pkg::*;

  localparam int unsigned W   = ELEM_WIDTH;
  localparam int unsigned DW  = 3*W + 2;
  localparam int unsigned MW  = 3*W + 1;
  localparam int unsigned SW  = (MW > DET_W) ? MW : DET_W;
  localparam int unsigned LAT = W + 5;

  logic en;
  logic [LAT-1:0] vld_q;

  logic signed [W-1:0]   a_in [NUM_ENT];
  logic signed [2*W:0]   adj_a [NUM_ENT];
  logic signed [W-1:0]   row_a [3];
  logic signed [2*W:0]   adj_d [NUM_ENT];
  logic signed [DW-1:0]  det;
  logic signed [DW-1:0]  det_n;
  logic                  dneg;
  logic [MW-1:0]         dmag;
  logic [SW-1:0]         dsh;
  logic                  dbig;
  det_word_t             dval;
  logic signed [W-1:0]   q [NUM_ENT];

  det_word_t             dval_q [W];
  logic                  sing_q [W];
  logic signed [W-1:0]   inv_q [NUM_ENT];
  det_word_t             det_out_q;
  logic                  sing_out_q;

  // freeze everything while the output word is held
  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  assign a_in[0] = a_r0c0_i;
  assign a_in[1] = a_r0c1_i;
  assign a_in[2] = a_r0c2_i;
  assign a_in[3] = a_r1c0_i;
  assign a_in[4] = a_r1c1_i;
  assign a_in[5] = a_r1c2_i;
  assign a_in[6] = a_r2c0_i;
  assign a_in[7] = a_r2c1_i;
  assign a_in[8] = a_r2c2_i;

  m3inv_adj #(.W(W)) u_adj (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a_in),
    .adj_o (adj_a),
    .row_o (row_a)
  );

  m3inv_det #(.W(W)) u_det (
    .clk_i (clk_i),
    .en_i  (en),
    .adj_i (adj_a),
    .row_i (row_a),
    .adj_o (adj_d),
    .det_o (det)
  );

  assign dneg  = det[DW-1];
  assign det_n = -det;
  assign dmag  = dneg ? det_n[MW-1:0] : det[MW-1:0];
  assign dsh   = SW'(dmag >> FRAC_BITS);
  assign dbig  = |dsh[SW-1:DET_W-1];

  always_comb begin
    if (dbig) begin
      dval = dneg ? DET_MIN : DET_MAX;
    end else if (dneg) begin
      dval = -dsh[DET_W-1:0];
    end else begin
      dval = dsh[DET_W-1:0];
    end
  end

  for (genvar e = 0; e < NUM_ENT; e++) begin : g_div
    m3inv_div #(.W(W), .F(FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .adj_i  (adj_d[e]),
      .dmag_i (dmag),
      .dneg_i (dneg),
      .q_o    (q[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dval_q[0] <= dval;
      sing_q[0] <= (det == '0);
      for (int i = 1; i < W; i++) begin
        dval_q[i] <= dval_q[i-1];
        sing_q[i] <= sing_q[i-1];
      end
      for (int e = 0; e < NUM_ENT; e++) begin
        inv_q[e] <= sing_q[W-1] ? '0 : q[e];
      end
      det_out_q  <= dval_q[W-1];
      sing_out_q <= sing_q[W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign inv_r0c0_o  = inv_q[0];
  assign inv_r0c1_o  = inv_q[1];
  assign inv_r0c2_o  = inv_q[2];
  assign inv_r1c0_o  = inv_q[3];
  assign inv_r1c1_o  = inv_q[4];
  assign inv_r1c2_o  = inv_q[5];
  assign inv_r2c0_o  = inv_q[6];
  assign inv_r2c1_o  = inv_q[7];
  assign inv_r2c2_o  = inv_q[8];
  assign det_value_o = det_out_q;
  assign singular_o  = sing_out_q;

endmodule
